// ----- rtl/core/dta_pkg.sv -----
// Shared types, constants and control structs of the descriptor triple allocator.
`timescale 1ns / 1ps
`default_nettype none

package dta_pkg;

  // Default pool size.
  localparam int DESCRIPTORS_DEF = 8;

  // Descriptors taken by one allocation.
  localparam int CHAIN_LEN = 3;
  localparam int PICK_W    = $clog2(CHAIN_LEN);

  // Fixed widths of the item fields.
  localparam int HEAD_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int IDX_OUT_W = 3;
  localparam int CNT_OUT_W = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_RANGE   = 2'd2,
    ST_DOUBLE  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;       // latch a new item, snapshot the free map
    logic    pick;        // record the lowest free descriptor of the snapshot
    logic    commit;      // apply the allocation, write the first link
    logic    link2;       // write the second link
    logic    walk;        // free the current descriptor, read its link
    logic    load_cur;    // follow the link just read
    logic    status_we;   // overwrite the item status
    status_t status_code;
    logic    load_out;    // move the finished result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_oob;    // head index beyond the pool
    logic found;       // the snapshot still holds a free descriptor
    logic pick_last;   // the next pick is the last of the chain
    logic cur_free;    // current descriptor is already free
    logic cur_linked;  // current descriptor links onward
    logic link_oob;    // link read back points beyond the pool
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/dta_ifs.sv -----
// Valid/ready channel interfaces for request items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface dta_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [dta_pkg::HEAD_W-1:0] head_index;

  modport source (output valid, action, head_index, input ready);
  modport sink   (input valid, action, head_index, output ready);
endinterface

interface dta_out_if;
  logic                        valid;
  logic                        ready;
  logic [dta_pkg::STATUS_W-1:0]  status;
  logic [dta_pkg::IDX_OUT_W-1:0] first_index;
  logic [dta_pkg::IDX_OUT_W-1:0] second_index;
  logic [dta_pkg::IDX_OUT_W-1:0] third_index;
  logic [dta_pkg::CNT_OUT_W-1:0] freed_count;

  modport source (output valid, status, first_index, second_index, third_index, freed_count,
                  input ready);
  modport sink   (input valid, status, first_index, second_index, third_index, freed_count,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/descriptor_triple_allocator_unit.sv -----
// Top level of the descriptor triple allocator: controller, datapath and channel ports.
`timescale 1ns / 1ps
`default_nettype none

// The unit keeps a pool of DESCRIPTORS ring descriptors with a free map and a link
// table. An allocate item (action 0) takes the three lowest-numbered free
// descriptors, all or nothing, links them first to second to third and returns
// their numbers; with fewer than three free it returns no room and leaves the pool
// as it was. A free item (action 1) walks the chain from head_index and frees each
// descriptor it reaches, returning the count; a head beyond the pool is rejected,
// and reaching a descriptor that is already free stops the walk with a double-free
// status while earlier descriptors stay freed. Freeing leaves the links in place,
// so freeing a stale head usually ends in a double free. The unit handles one item
// at a time and produces exactly one result item per request item. An allocation
// makes three picks with the one shared priority encoder, then two writes through
// the single write port of the link table, and then loads the result. A free
// steps through S_WALK and S_FETCH for each descriptor that links onward, because
// every link comes out of the link table through its registered read port; the
// walk ends at the last descriptor it frees or at one that is already free, and
// the result is then loaded; a rejected head goes straight to loading the result.
// The result waits in an output register, and a new request item is accepted while
// an earlier result still waits to be taken. After reset every descriptor is free.

module descriptor_triple_allocator_unit #(
  parameter int DESCRIPTORS = dta_pkg::DESCRIPTORS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dta_in_if.sink      in_ch,
  dta_out_if.source   out_ch
);
  import dta_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns the handshakes and the sequencing.
  dta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the pool state and the result register.
  dta_datapath #(
    .DESCRIPTORS (DESCRIPTORS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_ch.action),
    .in_head_index    (in_ch.head_index),
    .cmd              (cmd),
    .stat             (stat),
    .out_status       (out_ch.status),
    .out_first_index  (out_ch.first_index),
    .out_second_index (out_ch.second_index),
    .out_third_index  (out_ch.third_index),
    .out_freed_count  (out_ch.freed_count)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dta_datapath.sv -----
// Datapath: free map, link valid bits, link table memory, walk and pick registers.
`timescale 1ns / 1ps
`default_nettype none

module dta_datapath #(
  parameter int DESCRIPTORS = dta_pkg::DESCRIPTORS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_action,
  input  wire logic [dta_pkg::HEAD_W-1:0]    in_head_index,
  input  wire dta_pkg::dp_cmd_t              cmd,
  output dta_pkg::dp_stat_t                  stat,
  output logic [dta_pkg::STATUS_W-1:0]       out_status,
  output logic [dta_pkg::IDX_OUT_W-1:0]      out_first_index,
  output logic [dta_pkg::IDX_OUT_W-1:0]      out_second_index,
  output logic [dta_pkg::IDX_OUT_W-1:0]      out_third_index,
  output logic [dta_pkg::CNT_OUT_W-1:0]      out_freed_count
);
  import dta_pkg::*;

  localparam int IDX_W = $clog2(DESCRIPTORS);
  localparam int CNT_W = $clog2(DESCRIPTORS + 1);

  logic [DESCRIPTORS-1:0] free_map_r;
  logic [DESCRIPTORS-1:0] link_valid_r;
  logic [DESCRIPTORS-1:0] scratch_r;
  logic [IDX_W-1:0]       link_mem [DESCRIPTORS];
  logic [IDX_W-1:0]       rdata_r;

  logic [IDX_W-1:0]  cur_r;
  logic [CNT_W-1:0]  count_r;
  logic [PICK_W-1:0] pick_k_r;
  logic [IDX_W-1:0]  pick_r [CHAIN_LEN];
  logic              is_alloc_r;
  status_t           status_r;

  logic [IDX_W-1:0] enc_idx;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic             alloc_ok;

  // Lowest set bit of the snapshot.
  always_comb begin
    enc_idx = '0;
    for (int i = DESCRIPTORS - 1; i >= 0; i--) begin
      if (scratch_r[i]) begin
        enc_idx = IDX_W'(i);
      end
    end
  end

  assign stat.head_oob   = (in_head_index >= HEAD_W'(DESCRIPTORS));
  assign stat.found      = |scratch_r;
  assign stat.pick_last  = (pick_k_r == PICK_W'(CHAIN_LEN - 1));
  assign stat.cur_free   = free_map_r[cur_r];
  assign stat.cur_linked = link_valid_r[cur_r];
  assign stat.link_oob   = ({1'b0, rdata_r} >= (IDX_W + 1)'(DESCRIPTORS));

  // Pool state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r   <= '1;
      link_valid_r <= '0;
    end else begin
      if (cmd.commit) begin
        free_map_r                <= scratch_r;
        link_valid_r[pick_r[0]]   <= 1'b1;
        link_valid_r[pick_r[1]]   <= 1'b1;
        link_valid_r[pick_r[2]]   <= 1'b0;
      end
      if (cmd.walk) begin
        free_map_r[cur_r] <= 1'b1;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      scratch_r  <= free_map_r;
      cur_r      <= in_head_index[IDX_W-1:0];
      count_r    <= '0;
      pick_k_r   <= '0;
      is_alloc_r <= ~in_action;
    end
    if (cmd.pick) begin
      pick_r[pick_k_r]   <= enc_idx;
      scratch_r[enc_idx] <= 1'b0;
      pick_k_r           <= pick_k_r + PICK_W'(1);
    end
    if (cmd.walk) begin
      count_r <= count_r + CNT_W'(1);
    end
    if (cmd.load_cur) begin
      cur_r <= rdata_r;
    end
    // A status written together with the start of an item wins over the default.
    if (cmd.status_we) begin
      status_r <= cmd.status_code;
    end else if (cmd.start) begin
      status_r <= ST_OK;
    end
  end

  // Link table: one write port, one registered read port addressed by the walk.
  assign mem_we  = cmd.commit | cmd.link2;
  assign wr_addr = cmd.commit ? pick_r[0] : pick_r[1];
  assign wr_data = cmd.commit ? pick_r[1] : pick_r[2];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[wr_addr] <= wr_data;
    end
    rdata_r <= link_mem[cur_r];
  end

  // Output payload register.
  assign alloc_ok = is_alloc_r && (status_r == ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status       <= status_r;
      out_first_index  <= alloc_ok ? IDX_OUT_W'(pick_r[0]) : '0;
      out_second_index <= alloc_ok ? IDX_OUT_W'(pick_r[1]) : '0;
      out_third_index  <= alloc_ok ? IDX_OUT_W'(pick_r[2]) : '0;
      out_freed_count  <= is_alloc_r ? '0 : CNT_OUT_W'(count_r);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dta_ctrl.sv -----
// Controller: sequences allocation picks, link writes and chain walks.
`timescale 1ns / 1ps
`default_nettype none

module dta_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_action,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dta_pkg::dp_cmd_t       cmd,
  input  wire dta_pkg::dp_stat_t stat
);
  import dta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_COMMIT,
    S_LINK,
    S_WALK,
    S_FETCH,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.status_code = ST_OK;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (!in_action) begin
            state_nxt = S_PICK;
          end else if (stat.head_oob) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_PICK: begin
        if (!stat.found) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_NO_ROOM;
          state_nxt       = S_FINISH;
        end else begin
          cmd.pick = 1'b1;
          if (stat.pick_last) begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_LINK;
      end
      S_LINK: begin
        cmd.link2 = 1'b1;
        state_nxt = S_FINISH;
      end
      S_WALK: begin
        if (stat.cur_free) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_DOUBLE;
          state_nxt       = S_FINISH;
        end else begin
          cmd.walk  = 1'b1;
          state_nxt = stat.cur_linked ? S_FETCH : S_FINISH;
        end
      end
      S_FETCH: begin
        if (stat.link_oob) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_RANGE;
          state_nxt       = S_FINISH;
        end else begin
          cmd.load_cur = 1'b1;
          state_nxt    = S_WALK;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // A head beyond the pool is reported at once.
    if (state_r == S_IDLE && in_valid && in_action && stat.head_oob) begin
      cmd.status_we   = 1'b1;
      cmd.status_code = ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire
